// File: hdl/olads_pkg.sv
// ============================================================================
// olads_pkg
// Shared types and codes for the ordered list block: operation codes,
// result status codes, controller states and the per-cell command bundle.
// ============================================================================
`default_nettype none

package olads_pkg;

    // Operation carried in the input tuser
    typedef enum logic [2:0] {
        OP_INSERT = 3'd0,
        OP_DELETE = 3'd1,
        OP_SEARCH = 3'd2,
        OP_CLEAR  = 3'd3,
        OP_DUMP   = 3'd4
    } op_t;

    // Result status carried in the output tuser
    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_NOT_FOUND = 2'd1,
        STAT_FULL      = 2'd2,
        STAT_EMPTY     = 2'd3
    } status_t;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PICK,
        ST_FINISH,
        ST_DUMP
    } state_t;

    // What a cell does with its entry this cycle
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_SHIFT,
        CELL_WRAP
    } cell_cmd_t;

    // Control bundle from the controller to one cell
    typedef struct packed {
        cell_cmd_t cmd;
        logic      cmp_en;
    } cell_ctrl_t;

    // Fixed field widths of the stream ports
    localparam int ITEM_W      = 32;
    localparam int OP_W        = 3;
    localparam int POS_W       = 4;
    localparam int STATUS_W    = 2;
    localparam int COUNT_W     = 5;
    localparam int OUT_TDATA_W = 48;

endpackage

`default_nettype wire

// File: hdl/olads_cell.sv
// ============================================================================
// olads_cell
// One list cell: holds one entry, takes a new value, its right neighbor's
// entry or the head entry, and registers an equality compare bit.
// ============================================================================
`default_nettype none

module olads_cell #(
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                   clk,
    input  wire olads_pkg::cell_ctrl_t  ctrl,
    input  wire logic [VALUE_WIDTH-1:0] in_value,
    input  wire logic [VALUE_WIDTH-1:0] right_value,
    input  wire logic [VALUE_WIDTH-1:0] head_value,
    output logic      [VALUE_WIDTH-1:0] entry,
    output logic                        match
);
    import olads_pkg::*;

    logic [VALUE_WIDTH-1:0] entry_reg;
    logic [VALUE_WIDTH-1:0] entry_next;
    logic                   match_reg;

    // entry source select
    always_comb
    begin
        case (ctrl.cmd)
            CELL_HOLD:  entry_next = entry_reg;
            CELL_LOAD:  entry_next = in_value;
            CELL_SHIFT: entry_next = right_value;
            CELL_WRAP:  entry_next = head_value;
            default:    entry_next = entry_reg;
        endcase
    end

    // entry and compare bit; payload only, no reset
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        if (ctrl.cmp_en)
        begin
            match_reg <= (entry_reg == in_value);
        end
    end

    assign entry = entry_reg;
    assign match = match_reg;

endmodule

`default_nettype wire

// File: hdl/olads_pick.sv
// ============================================================================
// olads_pick
// First-match picker: priority-encodes the cells' hit bits, lowest index
// wins, and registers the found flag and index.
// ============================================================================
`default_nettype none

module olads_pick #(
    parameter int CAPACITY = 16,
    parameter int IDX_W    = 4
) (
    input  wire logic                clk,
    input  wire logic [CAPACITY-1:0] hit,
    output logic                     found,
    output logic      [IDX_W-1:0]    index
);
    import olads_pkg::*;

    logic             found_reg;
    logic             found_next;
    logic [IDX_W-1:0] index_reg;
    logic [IDX_W-1:0] index_next;

    // lowest set hit bit
    always_comb
    begin
        found_next = |hit;
        index_next = '0;
        for (int i = CAPACITY - 1; i >= 0; i--)
        begin
            if (hit[i])
            begin
                index_next = IDX_W'(i);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        found_reg <= found_next;
        index_reg <= index_next;
    end

    assign found = found_reg;
    assign index = index_reg;

endmodule

`default_nettype wire

// File: hdl/ordered_list_append_delete_search.sv
// ============================================================================
// ordered_list_append_delete_search
// Bounded ordered list of values kept in a row of cells, with append,
// delete-first-match, search, clear and dump over stream ports.
// ============================================================================
// One item is taken at a time; the input is ready only while the controller
// is idle. Insert and clear go from idle to finish; search and delete pass
// the pick state first (cell compare, then first-match pick); a dump emits
// one beat per entry, or one empty-status beat: the cell row rotates one
// place per emitted beat so that the head cell always supplies the next
// entry and the list is back in order after the last one. A result waiting
// in the output register does not stall the next item's acceptance; a
// stalled output holds the controller only when it has a new beat to load.
`default_nettype none

module ordered_list_append_delete_search #(
    parameter int CAPACITY    = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // input stream
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  wire logic [olads_pkg::ITEM_W-1:0]       s_axis_tdata,  // [31:0] item_value
    input  wire logic [olads_pkg::OP_W-1:0]         s_axis_tuser,  // [2:0] operation
    // output stream
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    output logic      [olads_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,  // [31:0] out_value,
                                                                   // [35:32] position,
                                                                   // [40:36] entry_count
    output logic      [olads_pkg::STATUS_W-1:0]     m_axis_tuser,  // [1:0] status
    output logic                                    m_axis_tlast   // last
);
    import olads_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    // control state
    state_t            state_reg;
    state_t            state_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [IDX_W-1:0]  dump_idx_reg;
    logic [IDX_W-1:0]  dump_idx_next;
    logic              out_valid_reg;
    logic              out_valid_next;

    // payload
    op_t               op_reg;
    logic [ITEM_W-1:0] val_reg;
    logic [ITEM_W-1:0] out_value_reg;
    logic [ITEM_W-1:0] out_value_next;
    logic [POS_W-1:0]  out_pos_reg;
    logic [POS_W-1:0]  out_pos_next;
    status_t           out_status_reg;
    status_t           out_status_next;
    logic [COUNT_W-1:0] out_count_reg;
    logic [COUNT_W-1:0] out_count_next;
    logic              out_last_reg;
    logic              out_last_next;
    logic              out_load;

    logic              accept;
    logic              out_free;
    op_t               in_op;

    // cell row
    cell_ctrl_t             cell_ctrl [CAPACITY];
    logic [VALUE_WIDTH-1:0] cell_entry [CAPACITY];
    logic [CAPACITY-1:0]    cell_match;
    logic [CAPACITY-1:0]    hit;
    logic [VALUE_WIDTH-1:0] cell_value;

    logic                   pick_found;
    logic [IDX_W-1:0]       pick_index;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign in_op         = op_t'(s_axis_tuser);

    // value fed to the cells: the incoming beat for compare, the held item for load
    assign cell_value = (state_reg == ST_IDLE) ? VALUE_WIDTH'(s_axis_tdata)
                                               : VALUE_WIDTH'(val_reg);

    // cells
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        localparam int RIGHT = (g == CAPACITY - 1) ? 0 : g + 1;

        olads_cell #(
            .VALUE_WIDTH (VALUE_WIDTH)
        ) u_cell (
            .clk         (clk),
            .ctrl        (cell_ctrl[g]),
            .in_value    (cell_value),
            .right_value (cell_entry[RIGHT]),
            .head_value  (cell_entry[0]),
            .entry       (cell_entry[g]),
            .match       (cell_match[g])
        );

        // only cells holding a live entry may hit
        assign hit[g] = cell_match[g] && (CNT_W'(g) < count_reg);
    end

    olads_pick #(
        .CAPACITY (CAPACITY),
        .IDX_W    (IDX_W)
    ) u_pick (
        .clk   (clk),
        .hit   (hit),
        .found (pick_found),
        .index (pick_index)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (in_op)
                        OP_INSERT: state_next = ST_FINISH;
                        OP_CLEAR:  state_next = ST_FINISH;
                        OP_DELETE: state_next = ST_PICK;
                        OP_SEARCH: state_next = ST_PICK;
                        OP_DUMP:   state_next = ST_DUMP;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_PICK:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DUMP:
            begin
                if (out_free)
                begin
                    if (count_reg == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (CNT_W'(dump_idx_reg) + CNT_W'(1) == count_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs: cell commands, count, dump index and result beat
    always_comb
    begin
        count_next      = count_reg;
        dump_idx_next   = dump_idx_reg;
        out_load        = 1'b0;
        out_value_next  = val_reg;
        out_pos_next    = '0;
        out_status_next = STAT_OK;
        out_last_next   = 1'b1;
        for (int i = 0; i < CAPACITY; i++)
        begin
            cell_ctrl[i].cmd    = CELL_HOLD;
            cell_ctrl[i].cmp_en = accept;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    dump_idx_next = '0;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_load = 1'b1;
                    case (op_reg)
                        OP_INSERT:
                        begin
                            if (count_reg >= CNT_W'(CAPACITY))
                            begin
                                out_status_next = STAT_FULL;
                            end
                            else
                            begin
                                for (int i = 0; i < CAPACITY; i++)
                                begin
                                    if (CNT_W'(i) == count_reg)
                                    begin
                                        cell_ctrl[i].cmd = CELL_LOAD;
                                    end
                                end
                                count_next   = count_reg + CNT_W'(1);
                                out_pos_next = POS_W'(32'(count_reg));
                            end
                        end
                        OP_DELETE:
                        begin
                            if (pick_found)
                            begin
                                // close the gap: entries after the match move left
                                for (int i = 0; i < CAPACITY; i++)
                                begin
                                    if ((IDX_W'(i) >= pick_index) &&
                                        (CNT_W'(i) + CNT_W'(1) < count_reg))
                                    begin
                                        cell_ctrl[i].cmd = CELL_SHIFT;
                                    end
                                end
                                count_next   = count_reg - CNT_W'(1);
                                out_pos_next = POS_W'(32'(pick_index));
                            end
                            else
                            begin
                                out_status_next = STAT_NOT_FOUND;
                            end
                        end
                        OP_SEARCH:
                        begin
                            if (pick_found)
                            begin
                                out_pos_next = POS_W'(32'(pick_index));
                            end
                            else
                            begin
                                out_status_next = STAT_NOT_FOUND;
                            end
                        end
                        OP_CLEAR:
                        begin
                            count_next     = '0;
                            out_value_next = '0;
                        end
                        default:
                        begin
                            out_load = 1'b0;
                        end
                    endcase
                end
            end
            ST_DUMP:
            begin
                if (out_free)
                begin
                    out_load = 1'b1;
                    if (count_reg == '0)
                    begin
                        out_value_next  = '0;
                        out_status_next = STAT_EMPTY;
                    end
                    else
                    begin
                        // head cell supplies the beat; rotate the live part of the row
                        out_value_next = ITEM_W'(cell_entry[0]);
                        out_pos_next   = POS_W'(32'(dump_idx_reg));
                        out_last_next  = (CNT_W'(dump_idx_reg) + CNT_W'(1) == count_reg);
                        for (int i = 0; i < CAPACITY; i++)
                        begin
                            if (CNT_W'(i) + CNT_W'(1) < count_reg)
                            begin
                                cell_ctrl[i].cmd = CELL_SHIFT;
                            end
                            else if (CNT_W'(i) + CNT_W'(1) == count_reg)
                            begin
                                cell_ctrl[i].cmd = CELL_WRAP;
                            end
                        end
                        dump_idx_next = dump_idx_reg + IDX_W'(1);
                    end
                end
            end
            default:
            begin
                out_load = 1'b0;
            end
        endcase

        out_count_next = COUNT_W'(32'(count_next));
    end

    // output valid
    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            dump_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            dump_idx_reg  <= dump_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= in_op;
            val_reg <= s_axis_tdata;
        end
        if (out_load)
        begin
            out_value_reg  <= out_value_next;
            out_pos_reg    <= out_pos_next;
            out_status_reg <= out_status_next;
            out_count_reg  <= out_count_next;
            out_last_reg   <= out_last_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {(OUT_TDATA_W - ITEM_W - POS_W - COUNT_W)'(0),
                            out_count_reg, out_pos_reg, out_value_reg};
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tlast  = out_last_reg;

`ifndef SYNTHESIS
    // fill count never goes past the row length
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    // the count moves only when a single-beat operation completes
    a_count_change: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(count_reg) |-> $past(state_reg) == ST_FINISH)
        else $error("entry count changed outside completion");

    // search and delete go through the pick stage
    a_pick_path: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (in_op == OP_SEARCH || in_op == OP_DELETE) |=> state_reg == ST_PICK)
        else $error("compare not followed by pick");

    // an empty-list beat is single and reports no entries
    a_empty_beat: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == STAT_EMPTY |-> m_axis_tlast && out_count_reg == '0)
        else $error("empty status with entries or without last");
`endif

endmodule

`default_nettype wire
